// ===== sv/bds_pkg.sv =====
package bds_pkg;

	// configuration port
	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W  = 3;

	localparam logic [CFG_IDX_W-1:0] REG_DUTY_LIM    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_SLEW    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DEADTIME_MS = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_MS  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MM_GAIN     = 3'd4;

	localparam logic [15:0] DEADTIME_RESET = 16'd200;
	localparam logic [15:0] TIMEOUT_RESET  = 16'd250;
	localparam logic [9:0]  GAIN_RESET     = 10'd1;

	// command modes
	localparam logic [1:0] MODE_HOLD   = 2'd0;
	localparam logic [1:0] MODE_MANUAL = 2'd1;
	localparam logic [1:0] MODE_AUTO   = 2'd2;

	// fault codes
	localparam logic [1:0] FLT_CLEAR   = 2'd0;
	localparam logic [1:0] FLT_STALE   = 2'd1;
	localparam logic [1:0] FLT_STOP    = 2'd2;
	localparam logic [1:0] FLT_BAD_CMD = 2'd3;

	// drive states
	localparam logic [1:0] DS_NEUTRAL = 2'd0;
	localparam logic [1:0] DS_ACTIVE  = 2'd1;
	localparam logic [1:0] DS_ESTOP   = 2'd2;

	// one control tick as captured at the input
	typedef struct packed {
		logic [31:0]        now_ms;
		logic               estop;
		logic               cmd_present;
		logic               cmd_valid;
		logic [30:0]        cmd_seq;
		logic [1:0]         mode;
		logic signed [15:0] cmd_target_mm;
		logic signed [15:0] cmd_manual;
		logic               cmd_enable;
	} tick_t;

	// supervisor control state apart from the duty values
	typedef struct packed {
		logic        have_seq;
		logic [30:0] last_seq;
		logic [31:0] last_cmd_time;
		logic        enabled;
		logic [31:0] deadtime_end;
		logic [1:0]  fault;
	} ctl_t;

endpackage

// ===== sv/bds_if.sv =====
interface bds_tick_if;
	logic               valid;
	logic               ready;
	logic [31:0]        now_ms;
	logic               estop;
	logic               cmd_present;
	logic               cmd_valid;
	logic [30:0]        cmd_seq;
	logic [1:0]         mode;
	logic signed [15:0] cmd_target_mm;
	logic signed [15:0] cmd_manual;
	logic               cmd_enable;

	modport source (
		output valid, now_ms, estop, cmd_present, cmd_valid, cmd_seq, mode,
			cmd_target_mm, cmd_manual, cmd_enable,
		input ready
	);
	modport sink (
		input valid, now_ms, estop, cmd_present, cmd_valid, cmd_seq, mode,
			cmd_target_mm, cmd_manual, cmd_enable,
		output ready
	);
endinterface

interface bds_result_if #(
	parameter int DUTY_BITS = 10
);
	logic                 valid;
	logic                 ready;
	logic [DUTY_BITS-1:0] raise_duty;
	logic [DUTY_BITS-1:0] lower_duty;
	logic [1:0]           drive_state;
	logic [1:0]           fault_code;
	logic signed [31:0]   seq_ack;
	logic [31:0]          command_age_ms;

	modport source (
		output valid, raise_duty, lower_duty, drive_state, fault_code, seq_ack,
			command_age_ms,
		input ready
	);
	modport sink (
		input valid, raise_duty, lower_duty, drive_state, fault_code, seq_ack,
			command_age_ms,
		output ready
	);
endinterface

// ===== sv/bidirectional_drive_supervisor_core.sv =====
// Bidirectional drive supervisor: each tick word carries the time, the e-stop level and an
// optional decoded command; each tick gives exactly one result word with the raise and lower
// duties, drive state, fault code, last accepted sequence number and command age. A tick is
// registered on entry and the whole supervisor update (sequence check, mode request with
// gain multiply and clamp, e-stop and timeout hard zero, direction lockout, dead-time and
// slew limit) is done by one combinational step into the result register, so the block takes
// one tick per clock while results are taken; the rate is set by the state update of that step.
// The result register lets a new tick enter while a finished result waits. Configuration
// registers are written through wr_en, wr_index and wr_data; the user must write them only
// while no tick is in flight (not enforced by the block); an index past the list is ignored.
module bidirectional_drive_supervisor_core #(
	parameter int DUTY_BITS = 10
) (
	input  logic                                clk,
	input  logic                                arst_n,
	bds_tick_if.sink                            tick,
	bds_result_if.source                        result,
	input  logic                                wr_en,
	input  logic [bds_pkg::CFG_IDX_W-1:0]       wr_index,
	input  logic [bds_pkg::CFG_DATA_W-1:0]      wr_data
);
	import bds_pkg::*;

	localparam int DW = DUTY_BITS + 1;

	logic [DUTY_BITS-1:0] duty_lim_q;
	logic [DUTY_BITS-1:0] max_slew_q;
	logic [15:0]          deadtime_ms_q;
	logic [15:0]          timeout_ms_q;
	logic [9:0]           mm_gain_q;

	tick_t                tick_s1;
	logic                 valid_s1;
	logic                 adv;

	ctl_t                 ctl_q;
	ctl_t                 ctl_n;
	logic signed [DW-1:0] req_q;
	logic signed [DW-1:0] req_n;
	logic signed [DW-1:0] applied_q;
	logic signed [DW-1:0] applied_n;

	logic [DUTY_BITS-1:0] raise_n;
	logic [DUTY_BITS-1:0] lower_n;
	logic [1:0]           state_n;
	logic signed [31:0]   seq_ack_n;
	logic [31:0]          age_n;

	logic                 out_valid_q;
	logic [DUTY_BITS-1:0] raise_q;
	logic [DUTY_BITS-1:0] lower_q;
	logic [1:0]           state_q;
	logic [1:0]           fault_q;
	logic signed [31:0]   seq_ack_q;
	logic [31:0]          age_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			duty_lim_q    <= '0;
			max_slew_q    <= DUTY_BITS'(1);
			deadtime_ms_q <= DEADTIME_RESET;
			timeout_ms_q  <= TIMEOUT_RESET;
			mm_gain_q     <= GAIN_RESET;
		end else if (wr_en) begin
			case (wr_index)
				REG_DUTY_LIM:    duty_lim_q    <= wr_data[DUTY_BITS-1:0];
				REG_MAX_SLEW:    max_slew_q    <= wr_data[DUTY_BITS-1:0];
				REG_DEADTIME_MS: deadtime_ms_q <= wr_data[15:0];
				REG_TIMEOUT_MS:  timeout_ms_q  <= wr_data[15:0];
				REG_MM_GAIN:     mm_gain_q     <= wr_data[9:0];
				default: ;
			endcase
		end
	end

	// handshake: the stage moves when the result register is free or being taken
	assign adv        = valid_s1 && (!out_valid_q || result.ready);
	assign tick.ready = !valid_s1 || adv;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (tick.ready) begin
			valid_s1 <= tick.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (tick.ready && tick.valid) begin
			tick_s1.now_ms        <= tick.now_ms;
			tick_s1.estop         <= tick.estop;
			tick_s1.cmd_present   <= tick.cmd_present;
			tick_s1.cmd_valid     <= tick.cmd_valid;
			tick_s1.cmd_seq       <= tick.cmd_seq;
			tick_s1.mode          <= tick.mode;
			tick_s1.cmd_target_mm <= tick.cmd_target_mm;
			tick_s1.cmd_manual    <= tick.cmd_manual;
			tick_s1.cmd_enable    <= tick.cmd_enable;
		end
	end

	// supervisor update
	bds_step #(
		.DUTY_BITS(DUTY_BITS)
	) u_step (
		.tick_s1        (tick_s1),
		.ctl_q          (ctl_q),
		.req_q          (req_q),
		.applied_q      (applied_q),
		.duty_lim       (duty_lim_q),
		.max_slew       (max_slew_q),
		.deadtime_ms    (deadtime_ms_q),
		.timeout_ms     (timeout_ms_q),
		.mm_gain        (mm_gain_q),
		.ctl_n          (ctl_n),
		.req_n          (req_n),
		.applied_n      (applied_n),
		.raise_duty     (raise_n),
		.lower_duty     (lower_n),
		.drive_state    (state_n),
		.seq_ack        (seq_ack_n),
		.command_age_ms (age_n)
	);

	// loop state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q     <= '0;
			req_q     <= '0;
			applied_q <= '0;
		end else if (adv) begin
			ctl_q     <= ctl_n;
			req_q     <= req_n;
			applied_q <= applied_n;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			raise_q   <= raise_n;
			lower_q   <= lower_n;
			state_q   <= state_n;
			fault_q   <= ctl_n.fault;
			seq_ack_q <= seq_ack_n;
			age_q     <= age_n;
		end
	end

	assign result.valid          = out_valid_q;
	assign result.raise_duty     = raise_q;
	assign result.lower_duty     = lower_q;
	assign result.drive_state    = state_q;
	assign result.fault_code     = fault_q;
	assign result.seq_ack        = seq_ack_q;
	assign result.command_age_ms = age_q;

	// raise and lower are never driven together
	a_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (raise_q == 0 || lower_q == 0))
		else $error("raise and lower duties both nonzero");

	// e-stop result shows zero drive and the e-stop fault
	a_estop_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && state_q == DS_ESTOP) |->
		(raise_q == 0 && lower_q == 0 && fault_q == FLT_STOP))
		else $error("e-stop result with drive or wrong fault");

	// a stalled tick stays in the input register
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv) |=> valid_s1)
		else $error("tick lost while stalled");

	// the applied duty is zero right after an e-stop tick
	a_estop_state: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && tick_s1.estop) |=> (applied_q == 0 && !ctl_q.enabled))
		else $error("applied duty not cleared by e-stop");

	// no new result is loaded while the previous one waits
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !result.ready) |-> !adv)
		else $error("pending result overwritten");

endmodule

// ===== sv/bds_step.sv =====
module bds_step #(
	parameter int DUTY_BITS = 10
) (
	input  bds_pkg::tick_t              tick_s1,
	input  bds_pkg::ctl_t               ctl_q,
	input  logic signed [DUTY_BITS:0]   req_q,
	input  logic signed [DUTY_BITS:0]   applied_q,
	input  logic [DUTY_BITS-1:0]        duty_lim,
	input  logic [DUTY_BITS-1:0]        max_slew,
	input  logic [15:0]                 deadtime_ms,
	input  logic [15:0]                 timeout_ms,
	input  logic [9:0]                  mm_gain,
	output bds_pkg::ctl_t               ctl_n,
	output logic signed [DUTY_BITS:0]   req_n,
	output logic signed [DUTY_BITS:0]   applied_n,
	output logic [DUTY_BITS-1:0]        raise_duty,
	output logic [DUTY_BITS-1:0]        lower_duty,
	output logic [1:0]                  drive_state,
	output logic signed [31:0]          seq_ack,
	output logic [31:0]                 command_age_ms
);
	import bds_pkg::*;

	localparam int DW = DUTY_BITS + 1;
	localparam int PW = 28;

	function automatic logic signed [PW-1:0] clamp(
		input logic signed [PW-1:0] v,
		input logic [DUTY_BITS-1:0] lim
	);
		logic signed [PW-1:0] l;
		l = signed'({{(PW-DUTY_BITS){1'b0}}, lim});
		if (v > l) begin
			clamp = l;
		end else if (v < -l) begin
			clamp = -l;
		end else begin
			clamp = v;
		end
	endfunction

	logic                 cmd_ok;
	logic signed [26:0]   product;
	logic signed [PW-1:0] req_cmd;
	logic signed [DW-1:0] req_mid;
	logic                 hard_zero;
	logic signed [DW-1:0] applied_cur;
	logic signed [DW-1:0] target;
	logic signed [PW-1:0] target_c;
	logic signed [PW-1:0] delta;
	logic signed [DW-1:0] applied_new;

	// sequence check on an arriving command
	assign cmd_ok = tick_s1.cmd_present && tick_s1.cmd_valid &&
		(!ctl_q.have_seq || (tick_s1.cmd_seq > ctl_q.last_seq));

	assign product = tick_s1.cmd_target_mm * signed'({1'b0, mm_gain});

	// requested duty from the command mode
	always_comb begin
		case (tick_s1.mode)
			MODE_MANUAL: req_cmd = clamp(PW'(tick_s1.cmd_manual), duty_lim);
			MODE_AUTO:   req_cmd = clamp(PW'(product), duty_lim);
			default:     req_cmd = '0;
		endcase
	end

	// command intake, then hard zero on e-stop or timeout
	always_comb begin
		ctl_n   = ctl_q;
		req_mid = req_q;
		if (tick_s1.cmd_present) begin
			if (cmd_ok) begin
				ctl_n.have_seq      = 1'b1;
				ctl_n.last_seq      = tick_s1.cmd_seq;
				ctl_n.enabled       = tick_s1.cmd_enable;
				ctl_n.last_cmd_time = tick_s1.now_ms;
				ctl_n.fault         = FLT_CLEAR;
				req_mid             = req_cmd[DW-1:0];
			end else begin
				ctl_n.enabled = 1'b0;
				ctl_n.fault   = FLT_BAD_CMD;
				req_mid       = '0;
			end
		end
		command_age_ms = tick_s1.now_ms - ctl_n.last_cmd_time;
		hard_zero      = tick_s1.estop || (command_age_ms >= {16'd0, timeout_ms});
		req_n          = req_mid;
		applied_cur    = applied_q;
		if (hard_zero) begin
			req_n         = '0;
			applied_cur   = '0;
			ctl_n.enabled = 1'b0;
			ctl_n.fault   = tick_s1.estop ? FLT_STOP : FLT_STALE;
		end

		// target with direction lockout and dead-time
		target = ctl_n.enabled ? req_n : '0;
		if (target != 0 && applied_cur != 0 && target[DW-1] != applied_cur[DW-1]) begin
			target = '0;
		end
		if (applied_cur == 0 && target != 0 && tick_s1.now_ms < ctl_q.deadtime_end) begin
			target = '0;
		end

		// slew limit toward the clamped target
		target_c    = clamp(PW'(target), duty_lim);
		delta       = clamp(target_c - PW'(applied_cur), max_slew);
		applied_new = applied_cur + delta[DW-1:0];
		applied_n   = applied_new;
		if (applied_cur != 0 && applied_new == 0) begin
			ctl_n.deadtime_end = tick_s1.now_ms + {16'd0, deadtime_ms};
		end
	end

	// result fields
	assign raise_duty = (applied_new > 0) ? applied_new[DUTY_BITS-1:0] : '0;
	assign lower_duty = (applied_new < 0) ? DUTY_BITS'(-applied_new) : '0;
	assign drive_state = tick_s1.estop ? DS_ESTOP :
		((applied_new != 0) ? DS_ACTIVE : DS_NEUTRAL);
	assign seq_ack = ctl_n.have_seq ? signed'({1'b0, ctl_n.last_seq}) : -32'sd1;

endmodule
